// ===== hw/rtl/life_like_automaton_grid_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the automaton grid checker
// Immediate-implication and next-cycle forms, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef LIFE_LIKE_AUTOMATON_GRID_ASSERT_SVH
`define LIFE_LIKE_AUTOMATON_GRID_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define LLAG_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define LLAG_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lla_pkg.sv =====
// ----------------------------------------------------------------------------
// lla_pkg
// Shared constants, codes and types of the Life-like automaton grid.
// ----------------------------------------------------------------------------
`default_nettype none

package lla_pkg;

  localparam int ROWS_DEF    = 64;
  localparam int COLS_DEF    = 64;
  localparam int QUEUE_DEPTH = 2;

  localparam int KIND_W    = 2;
  localparam int COORD_W   = 6;
  localparam int MASK_W    = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W     = 4;

  localparam logic [MASK_W-1:0] BIRTH_RESET   = 9'd8;
  localparam logic [MASK_W-1:0] SURVIVE_RESET = 9'd12;

  localparam logic [CFG_IDX_W-1:0] CFG_BIRTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SURVIVE = 2'd1;

  localparam logic [KIND_W-1:0] KIND_KILL   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REVIVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_STEP   = 2'd3;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_KILL,
    OP_REVIVE,
    OP_READ,
    OP_STEP
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_SWEEP,
    BK_DRAIN,
    BK_DONE
  } back_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lla_ram.sv =====
// ----------------------------------------------------------------------------
// lla_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lla_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lla_fifo.sv =====
// ----------------------------------------------------------------------------
// lla_fifo
// Short command queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
`default_nettype none

module lla_fifo #(
  parameter int DEPTH = lla_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lla_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output lla_pkg::cmd_t head
);

  import lla_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] count;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_cmd;
    end
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= ptr_inc(wp);
      end
      if (pop) begin
        rp <= ptr_inc(rp);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lla_front.sv =====
// ----------------------------------------------------------------------------
// lla_front
// Accepts input beats and classifies them into queue commands.
// ----------------------------------------------------------------------------
`default_nettype none

module lla_front #(
  parameter int ROWS = lla_pkg::ROWS_DEF,
  parameter int COLS = lla_pkg::COLS_DEF
) (
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lla_pkg::KIND_W-1:0]  kind,
  input  logic [lla_pkg::COORD_W-1:0] row,
  input  logic [lla_pkg::COORD_W-1:0] col,
  input  logic                        queue_full,
  input  logic                        clearing,
  output logic                        push,
  output lla_pkg::cmd_t               cmd
);

  import lla_pkg::*;

  logic in_grid;

  assign in_grid  = (int'(row) < ROWS) && (int'(col) < COLS);
  assign in_ready = !queue_full && !clearing;
  assign push     = in_valid && in_ready;

  always_comb begin
    cmd.row = row;
    cmd.col = col;
    case (kind)
      KIND_KILL:   cmd.op = in_grid ? OP_KILL : OP_NONE;
      KIND_REVIVE: cmd.op = in_grid ? OP_REVIVE : OP_NONE;
      KIND_READ:   cmd.op = in_grid ? OP_READ : OP_NONE;
      KIND_STEP:   cmd.op = OP_STEP;
      default:     cmd.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lla_back.sv =====
// ----------------------------------------------------------------------------
// lla_back
// Executes queued commands on the current and pending planes, runs the
// raster sweep of a generation and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lla_back #(
  parameter int ROWS = lla_pkg::ROWS_DEF,
  parameter int COLS = lla_pkg::COLS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  input  lla_pkg::cmd_t              cmd,
  output logic                       cmd_pop,
  input  logic [lla_pkg::MASK_W-1:0] birth_mask,
  input  logic [lla_pkg::MASK_W-1:0] survive_mask,
  output logic                       clearing,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       alive,
  output logic                       step_done
);

  import lla_pkg::*;

  localparam int N   = ROWS * COLS;
  localparam int AW  = $clog2(N);
  localparam int KW  = $clog2(N + COLS + 1);
  localparam int RCW = $clog2(ROWS);
  localparam int CCW = $clog2(COLS);
  localparam int SRL = 2 * COLS + 3;

  back_state_t state, state_next;

  logic [AW-1:0]  clr_addr;
  logic [KW-1:0]  k;
  logic [AW-1:0]  j_idx;
  logic [RCW-1:0] jr;
  logic [CCW-1:0] jc;
  logic           drain_cnt;

  logic           s1_valid, s2_valid;
  logic [AW-1:0]  s1_addr, s2_addr;
  logic [RCW-1:0] s1_r, s2_r;
  logic [CCW-1:0] s1_c, s2_c;
  logic           s2_pend;
  logic [SRL-1:0] sr;

  logic          cur_we, cur_re, cur_wdata, cur_rdata;
  logic [AW-1:0] cur_waddr, cur_raddr;
  logic          pend_we, pend_re, pend_wdata, pend_rdata;
  logic [AW-1:0] pend_waddr;

  logic          slot_free;
  logic [AW-1:0] cmd_addr;
  logic          cur_issue, j_issue;
  logic [CNT_W-1:0] n;
  logic          centre, interior, new_bit;
  logic          load_none, load_read, load_step;

  assign clearing  = (state == BK_CLEAR);
  assign slot_free = !out_valid || out_ready;
  assign cmd_addr  = AW'(int'(cmd.row) * COLS + int'(cmd.col));
  assign cur_issue = (state == BK_SWEEP) && (k < KW'(N));
  assign j_issue   = (state == BK_SWEEP) && (k >= KW'(COLS + 1));

  // 3x3 window: sr[0] is the newest cell, the centre trails by one row and one cell
  assign n = {3'b000, sr[0]} + {3'b000, sr[1]} + {3'b000, sr[2]}
           + {3'b000, sr[COLS]} + {3'b000, sr[COLS + 2]}
           + {3'b000, sr[2 * COLS]} + {3'b000, sr[2 * COLS + 1]}
           + {3'b000, sr[2 * COLS + 2]};
  assign centre   = sr[COLS + 1];
  assign interior = (s2_r != '0) && (s2_r != RCW'(ROWS - 1))
                 && (s2_c != '0) && (s2_c != CCW'(COLS - 1));

  always_comb begin
    if (!interior) begin
      new_bit = s2_pend;
    end else if (centre) begin
      new_bit = survive_mask[n] ? s2_pend : 1'b0;
    end else begin
      new_bit = birth_mask[n] ? 1'b1 : s2_pend;
    end
  end

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    load_none  = 1'b0;
    load_read  = 1'b0;
    load_step  = 1'b0;
    case (state)
      BK_CLEAR: begin
        if (clr_addr == AW'(N - 1)) begin
          state_next = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (cmd_valid && slot_free) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            OP_READ: state_next = BK_READ;
            OP_STEP: state_next = BK_SWEEP;
            default: load_none  = 1'b1;
          endcase
        end
      end
      BK_READ: begin
        load_read  = 1'b1;
        state_next = BK_IDLE;
      end
      BK_SWEEP: begin
        if (j_issue && (j_idx == AW'(N - 1))) begin
          state_next = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (drain_cnt) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        load_step  = 1'b1;
        state_next = BK_IDLE;
      end
      default: state_next = BK_CLEAR;
    endcase
  end

  // port muxing: clearing, cell commands and sweep never overlap
  always_comb begin
    cur_we     = clearing || s2_valid;
    cur_waddr  = clearing ? clr_addr : s2_addr;
    cur_wdata  = clearing ? 1'b0 : new_bit;
    cur_re     = cur_issue || (cmd_pop && (cmd.op == OP_READ));
    cur_raddr  = cur_issue ? k[AW-1:0] : cmd_addr;
    pend_re    = j_issue;
    pend_we    = 1'b0;
    pend_waddr = cmd_addr;
    pend_wdata = 1'b0;
    if (clearing) begin
      pend_we    = 1'b1;
      pend_waddr = clr_addr;
    end else if (s2_valid) begin
      pend_we    = 1'b1;
      pend_waddr = s2_addr;
      pend_wdata = new_bit;
    end else if (cmd_pop && (cmd.op == OP_KILL || cmd.op == OP_REVIVE)) begin
      pend_we    = 1'b1;
      pend_wdata = (cmd.op == OP_REVIVE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    sr      <= {sr[SRL-2:0], cur_rdata};
    s1_addr <= j_idx;
    s1_r    <= jr;
    s1_c    <= jc;
    s2_addr <= s1_addr;
    s2_r    <= s1_r;
    s2_c    <= s1_c;
    s2_pend <= pend_rdata;
    if (load_none || load_read || load_step) begin
      alive     <= load_read ? cur_rdata : 1'b0;
      step_done <= load_step;
    end
    if (rst) begin
      clr_addr  <= '0;
      k         <= '0;
      j_idx     <= '0;
      jr        <= '0;
      jc        <= '0;
      drain_cnt <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
      end
      s1_valid <= j_issue;
      s2_valid <= s1_valid;
      if (state == BK_SWEEP) begin
        k <= k + 1'b1;
      end else begin
        k <= '0;
      end
      if (j_issue) begin
        j_idx <= j_idx + 1'b1;
        if (jc == CCW'(COLS - 1)) begin
          jc <= '0;
          jr <= jr + 1'b1;
        end else begin
          jc <= jc + 1'b1;
        end
      end else if (state != BK_SWEEP) begin
        j_idx <= '0;
        jr    <= '0;
        jc    <= '0;
      end
      drain_cnt <= (state == BK_DRAIN) ? !drain_cnt : 1'b0;
      if (load_none || load_read || load_step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  lla_ram #(
    .WIDTH (1),
    .DEPTH (N)
  ) u_cur_ram (
    .clk   (clk),
    .we    (cur_we),
    .waddr (cur_waddr),
    .wdata (cur_wdata),
    .re    (cur_re),
    .raddr (cur_raddr),
    .rdata (cur_rdata)
  );

  lla_ram #(
    .WIDTH (1),
    .DEPTH (N)
  ) u_pend_ram (
    .clk   (clk),
    .we    (pend_we),
    .waddr (pend_waddr),
    .wdata (pend_wdata),
    .re    (pend_re),
    .raddr (j_idx),
    .rdata (pend_rdata)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/life_like_automaton_grid.sv =====
// ----------------------------------------------------------------------------
// life_like_automaton_grid
// Grid of cells with current and pending planes and a B/S rule generation step.
// ----------------------------------------------------------------------------
// Answers: kill, revive and off-grid items are answered from the idle state of the back,
//   a read through its read state, a step after the raster sweep, a drain and a done state.
// Throughput: kill and revive one a cycle while out_ready holds high; a read holds the back
//   through its read state, a step through the raster sweep, one cell read per cycle.
// Reset: clearing pass over every cell of both planes, in_ready low
//   throughout; configuration writes are taken during it.
`default_nettype none

module life_like_automaton_grid #(
  parameter int ROWS        = lla_pkg::ROWS_DEF,
  parameter int COLS        = lla_pkg::COLS_DEF,
  parameter int QUEUE_DEPTH = lla_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lla_pkg::KIND_W-1:0]    kind,
  input  logic [lla_pkg::COORD_W-1:0]   row,
  input  logic [lla_pkg::COORD_W-1:0]   col,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          alive,
  output logic                          step_done,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lla_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lla_pkg::MASK_W-1:0]    cfg_data
);

  import lla_pkg::*;

  logic [MASK_W-1:0] birth_mask;
  logic [MASK_W-1:0] survive_mask;
  logic              queue_full;
  logic              clearing;
  logic              push;
  cmd_t              push_cmd;
  logic              cmd_valid;
  logic              cmd_pop;
  cmd_t              head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      birth_mask   <= BIRTH_RESET;
      survive_mask <= SURVIVE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BIRTH:   birth_mask   <= cfg_data;
        CFG_SURVIVE: survive_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  lla_front #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .row        (row),
    .col        (col),
    .queue_full (queue_full),
    .clearing   (clearing),
    .push       (push),
    .cmd        (push_cmd)
  );

  lla_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (queue_full),
    .pop       (cmd_pop),
    .not_empty (cmd_valid),
    .head      (head)
  );

  lla_back #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd          (head),
    .cmd_pop      (cmd_pop),
    .birth_mask   (birth_mask),
    .survive_mask (survive_mask),
    .clearing     (clearing),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .alive        (alive),
    .step_done    (step_done)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/lla_checker.sv =====
// ----------------------------------------------------------------------------
// lla_checker
// Port-level checks of the automaton grid, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "life_like_automaton_grid_assert.svh"

module lla_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic alive,
  input logic step_done
);

  // a stalled result beat holds
  `LLAG_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(alive) && $stable(step_done), "result beat changed while stalled")

  // a read answer never also flags a finished generation
  `LLAG_ASSERT_IMP(a_out_excl, clk, rst, out_valid, !(alive && step_done), "alive and step_done both set")

  // the clearing pass follows reset: no beat taken or given straight after it
  `LLAG_ASSERT_IMP(a_clear_after_rst, clk, rst, $past(rst), !in_ready && !out_valid, "block active right after reset")

endmodule

bind life_like_automaton_grid lla_checker u_chk (.*);

`default_nettype wire

// ===== tb/life_like_automaton_grid_tb.sv =====
// ----------------------------------------------------------------------------
// life_like_automaton_grid_tb
// Self-checking bench for the Life-like automaton grid. A mirror of both cell
// planes and of the birth and survive rules predicts every result beat. Cell
// writes, reads and generation steps are driven with random sender bursts and
// receiver stalls across several rule settings, the extreme masks among them.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic alive;
  logic step_done;
} grid_answer_t;

class life_grid_mirror;
  logic [lla_pkg::MASK_W-1:0] birth_rule;
  logic [lla_pkg::MASK_W-1:0] survive_rule;
  bit                         live_now  [lla_pkg::ROWS_DEF][lla_pkg::COLS_DEF];
  bit                         live_next [lla_pkg::ROWS_DEF][lla_pkg::COLS_DEF];
  grid_answer_t               answers_due[$];
  int unsigned                mismatches;

  function new();
    birth_rule   = lla_pkg::BIRTH_RESET;
    survive_rule = lla_pkg::SURVIVE_RESET;
    mismatches   = 0;
  endfunction

  function void set_rule(logic [lla_pkg::CFG_IDX_W-1:0] idx,
                         logic [lla_pkg::MASK_W-1:0] data);
    case (idx)
      lla_pkg::CFG_BIRTH:   birth_rule = data;
      lla_pkg::CFG_SURVIVE: survive_rule = data;
      default: ;
    endcase
  endfunction

  // interior cells only; border pending bits are just carried across
  function void advance_generation();
    int n;
    for (int r = 1; r < lla_pkg::ROWS_DEF - 1; r++) begin
      for (int c = 1; c < lla_pkg::COLS_DEF - 1; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0) n += live_now[r + dr][c + dc];
          end
        end
        if (live_now[r][c]) begin
          if (!survive_rule[n]) live_next[r][c] = 1'b0;
        end else if (birth_rule[n]) begin
          live_next[r][c] = 1'b1;
        end
      end
    end
    live_now = live_next;
  endfunction

  function void take_item(logic [lla_pkg::KIND_W-1:0] k,
                          logic [lla_pkg::COORD_W-1:0] r,
                          logic [lla_pkg::COORD_W-1:0] c);
    grid_answer_t ans;
    bit           on_grid;
    ans     = '0;
    on_grid = (int'(r) < lla_pkg::ROWS_DEF) && (int'(c) < lla_pkg::COLS_DEF);
    case (k)
      lla_pkg::KIND_KILL:   if (on_grid) live_next[r][c] = 1'b0;
      lla_pkg::KIND_REVIVE: if (on_grid) live_next[r][c] = 1'b1;
      lla_pkg::KIND_READ:   ans.alive = on_grid ? live_now[r][c] : 1'b0;
      lla_pkg::KIND_STEP: begin
        advance_generation();
        ans.step_done = 1'b1;
      end
      default: ;
    endcase
    answers_due.push_back(ans);
  endfunction

  task report(string what);
    mismatches++;
    $display("mismatch %0d: %s", mismatches, what);
  endtask

  task match_answer(logic got_alive, logic got_done);
    grid_answer_t want;
    if (answers_due.size() == 0) begin
      report("result beat with no item outstanding");
    end else begin
      want = answers_due.pop_front();
      if (got_alive !== want.alive)
        report($sformatf("alive %b, expected %b", got_alive, want.alive));
      if (got_done !== want.step_done)
        report($sformatf("step_done %b, expected %b", got_done, want.step_done));
    end
  endtask
endclass

module life_like_automaton_grid_tb;
  import lla_pkg::*;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [KIND_W-1:0]  kind_code_t;

  localparam coord_t                  LAST_ROW       = coord_t'(ROWS_DEF - 1);
  localparam coord_t                  LAST_COL       = coord_t'(COLS_DEF - 1);
  localparam logic [CFG_IDX_W-1:0]    CFG_UNUSED_A   = 2'd2;
  localparam logic [CFG_IDX_W-1:0]    CFG_UNUSED_B   = 2'd3;
  localparam int                      PHASES         = 5;
  localparam int                      PHASE_ITEMS    = 18;
  localparam int                      HOLD_AFTER     = 30;
  localparam int                      HOLD_CYCLES    = 200;
  localparam int                      WATCHDOG_LIMIT = 40000;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [KIND_W-1:0]    kind      = '0;
  logic [COORD_W-1:0]   row       = '0;
  logic [COORD_W-1:0]   col       = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 alive;
  logic                 step_done;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [MASK_W-1:0]    cfg_data  = '0;

  life_grid_mirror mirror;
  int              items_sent   = 0;
  int              results_seen = 0;
  int              quiet_cycles = 0;
  int              burst_left   = 0;
  bit              steady       = 1'b0;

  life_like_automaton_grid u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .row       (row),
    .col       (col),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .alive     (alive),
    .step_done (step_done),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // sender bursts; a gap only opens at a burst boundary
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = steady ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send_item(input kind_code_t k, input coord_t r, input coord_t c);
    pace();
    in_valid <= 1'b1;
    kind     <= k;
    row      <= r;
    col      <= c;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    mirror.take_item(k, r, c);
    items_sent++;
  endtask

  task automatic program_rule(input logic [CFG_IDX_W-1:0] idx,
                              input logic [MASK_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    mirror.set_rule(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_answers();
    in_valid <= 1'b0;
    while (mirror.answers_due.size() != 0) @(posedge clk);
  endtask

  // seed a 5x5 patch, maybe kill one cell, maybe step, then read back inside the patch
  task automatic run_episode();
    int r0;
    int c0;
    int n_cells;
    int n_reads;
    if ($urandom_range(0, 7) == 0)
      r0 = $urandom_range(0, 1) ? 0 : ROWS_DEF - 5;
    else
      r0 = $urandom_range(1, ROWS_DEF - 6);
    if ($urandom_range(0, 7) == 0)
      c0 = $urandom_range(0, 1) ? 0 : COLS_DEF - 5;
    else
      c0 = $urandom_range(1, COLS_DEF - 6);
    n_cells = $urandom_range(3, 9);
    n_reads = $urandom_range(2, 5);
    repeat (n_cells)
      send_item(KIND_REVIVE, coord_t'(r0 + $urandom_range(0, 4)),
                coord_t'(c0 + $urandom_range(0, 4)));
    if ($urandom_range(0, 2) == 0)
      send_item(KIND_KILL, coord_t'(r0 + $urandom_range(0, 4)),
                coord_t'(c0 + $urandom_range(0, 4)));
    if ($urandom_range(0, 3) != 0)
      send_item(KIND_STEP, coord_t'($urandom), coord_t'($urandom));
    repeat (n_reads)
      send_item(KIND_READ, coord_t'(r0 + $urandom_range(0, 4)),
                coord_t'(c0 + $urandom_range(0, 4)));
  endtask

  task automatic noise_item();
    send_item(kind_code_t'($urandom_range(0, 2)), coord_t'($urandom), coord_t'($urandom));
  endtask

  initial begin : stimulus
    int phase_end;
    mirror = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // taken during the clearing pass
    program_rule(CFG_BIRTH, BIRTH_RESET);
    program_rule(CFG_SURVIVE, SURVIVE_RESET);

    send_item(KIND_READ, '0, '0);
    send_item(KIND_READ, LAST_ROW, LAST_COL);
    send_item(KIND_REVIVE, '0, '0);
    send_item(KIND_REVIVE, LAST_ROW, LAST_COL);
    send_item(KIND_REVIVE, '0, LAST_COL);
    send_item(KIND_REVIVE, LAST_ROW, '0);
    send_item(KIND_KILL, LAST_ROW, LAST_COL);
    send_item(KIND_READ, '0, '0);              // pending only, still dead
    send_item(KIND_REVIVE, 6'd10, 6'd10);      // blinker
    send_item(KIND_REVIVE, 6'd10, 6'd11);
    send_item(KIND_REVIVE, 6'd10, 6'd12);
    send_item(KIND_REVIVE, 6'd20, 6'd20);      // revived then killed before the step
    send_item(KIND_KILL, 6'd20, 6'd20);
    send_item(KIND_STEP, '0, '0);
    send_item(KIND_READ, '0, '0);
    send_item(KIND_READ, LAST_ROW, LAST_COL);
    send_item(KIND_READ, LAST_ROW, '0);
    send_item(KIND_READ, 6'd9, 6'd11);
    send_item(KIND_READ, 6'd10, 6'd10);
    send_item(KIND_STEP, 6'h2a, 6'h15);        // coordinates are don't-care here
    send_item(KIND_READ, 6'd10, 6'd10);
    send_item(KIND_READ, 6'd20, 6'd20);
    drain_answers();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          program_rule(CFG_BIRTH, 9'h008);
          program_rule(CFG_SURVIVE, 9'h00c);
        end
        1: begin
          program_rule(CFG_BIRTH, 9'h1ff);
          program_rule(CFG_SURVIVE, 9'h000);
          program_rule(CFG_UNUSED_A, 9'($urandom));
          program_rule(CFG_UNUSED_B, 9'($urandom));
        end
        2: begin
          program_rule(CFG_BIRTH, 9'h000);
          program_rule(CFG_SURVIVE, 9'h1ff);
        end
        3: begin
          program_rule(CFG_BIRTH, 9'($urandom));
          program_rule(CFG_SURVIVE, 9'($urandom));
        end
        default: begin
          program_rule(CFG_BIRTH, 9'h048);
          program_rule(CFG_SURVIVE, 9'h00c);
        end
      endcase
      steady     = (ph == 2);
      burst_left = 0;
      phase_end  = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 3) == 0)
          noise_item();
        else
          run_episode();
      end
      drain_answers();
    end

    repeat (16) @(posedge clk);
    if (mirror.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // stall pattern in segments; one long hold-off so the input backs up
  initial begin : receiver
    int seg_len;
    int mode;
    bit held_off;
    held_off = 1'b0;
    forever begin
      mode    = $urandom_range(0, 3);
      seg_len = $urandom_range(4, 48);
      repeat (seg_len) begin
        @(posedge clk);
        if (!held_off && results_seen >= HOLD_AFTER) begin
          held_off = 1'b1;
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      mirror.match_answer(alive, step_done);
      results_seen <= results_seen + 1;
    end
  end

  // the watchdog limit covers a step plus the clearing pass with no beat taken
  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready) ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/lla_pkg.sv
hw/rtl/lla_ram.sv
hw/rtl/lla_fifo.sv
hw/rtl/lla_front.sv
hw/rtl/lla_back.sv
hw/rtl/life_like_automaton_grid.sv
hw/rtl/lla_checker.sv
tb/life_like_automaton_grid_tb.sv
